@@ src/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the minimum tracking stack
// Opcodes, status codes, field widths and the shift control of the cell rows.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 7;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = 3 * DATA_W + OCC_W + 1 + STATUS_W;
  localparam int unsigned OUT_PAD  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_OBSERVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  // Shift command for a row of cells: push moves every entry one place deeper,
  // pop moves every entry one place toward the top.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

@@ src/min_tracking_stack.sv @@
// ----------------------------------------------------------------------------
// min_tracking_stack: LIFO stack of signed values with running minimum
// Two rows of shifting cells hold the elements and the minimum history.
// ----------------------------------------------------------------------------
// Output: each result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while each result is taken at once; a push or
//   pop shifts the affected cell rows by one place. A result
//   that waits holds the input off until the receiver takes it.
// Reset: the element and minimum counts and the output valid clear at once;
//   cell contents stay undefined until written and need no clearing pass.
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] value
  input  logic [1:0]   s_axis_tuser,   // [1:0] opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] popped_value, [63:32] top_value, [95:64] minimum,
  // [102:96] occupancy, [103] is_empty, [105:104] status, [111:106] zero
  output logic [111:0] m_axis_tdata
);
  import mts_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] min_cnt_q, min_cnt_d;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic                     accept;
  logic                     is_push, is_pop, full;
  logic                     push_ok, pop_ok, to_min, min_push, min_pop;
  logic signed [DATA_W-1:0] in_val;
  logic signed [DATA_W-1:0] elem_top, min_top;
  logic [DATA_W-1:0]        elem_top_raw, elem_next_raw, min_top_raw, min_next_raw;
  logic [DATA_W-1:0]        popped_res, top_res, min_res;
  logic [CNT_W+OCC_W-1:0]   occ_wide;
  status_e                  status_res;
  shift_ctrl_t              elem_ctrl, min_ctrl;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign in_val    = $signed(s_axis_tdata[DATA_W-1:0]);
  assign elem_top  = $signed(elem_top_raw);
  assign min_top   = $signed(min_top_raw);

  assign is_push = (s_axis_tuser == OP_PUSH);
  assign is_pop  = (s_axis_tuser == OP_POP);
  assign full    = (cnt_q == CNT_W'(STACK_DEPTH));

  assign push_ok = accept && is_push && !full;
  assign pop_ok  = accept && is_pop && (cnt_q != '0);

  // The minimum row never holds more entries than the element row.
  assign to_min   = (min_cnt_q == '0) || (in_val <= min_top);
  assign min_push = push_ok && to_min;
  assign min_pop  = pop_ok && (min_top == elem_top);

  assign elem_ctrl = '{push: push_ok, pop: pop_ok};
  assign min_ctrl  = '{push: min_push, pop: min_pop};

  mts_chain #(.DEPTH(STACK_DEPTH)) u_elem_chain (
    .clk_i       (clk_i),
    .ctrl_i      (elem_ctrl),
    .push_data_i (s_axis_tdata[DATA_W-1:0]),
    .top_o       (elem_top_raw),
    .next_o      (elem_next_raw)
  );

  mts_chain #(.DEPTH(STACK_DEPTH)) u_min_chain (
    .clk_i       (clk_i),
    .ctrl_i      (min_ctrl),
    .push_data_i (s_axis_tdata[DATA_W-1:0]),
    .top_o       (min_top_raw),
    .next_o      (min_next_raw)
  );

  always_comb begin
    cnt_d     = cnt_q;
    min_cnt_d = min_cnt_q;
    if (push_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_ok) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (min_push) begin
      min_cnt_d = min_cnt_q + CNT_W'(1);
    end else if (min_pop) begin
      min_cnt_d = min_cnt_q - CNT_W'(1);
    end
  end

  // Result fields describe the stack as it stands after this item.
  always_comb begin
    popped_res = pop_ok ? elem_top_raw : '0;

    if (push_ok) begin
      top_res = s_axis_tdata[DATA_W-1:0];
    end else if (pop_ok) begin
      top_res = (cnt_q > CNT_W'(1)) ? elem_next_raw : '0;
    end else begin
      top_res = (cnt_q != '0) ? elem_top_raw : '0;
    end

    if (cnt_d == '0) begin
      min_res = '0;
    end else if (min_push) begin
      min_res = s_axis_tdata[DATA_W-1:0];
    end else if (min_pop) begin
      min_res = min_next_raw;
    end else begin
      min_res = min_top_raw;
    end

    if (is_push && full) begin
      status_res = ST_PUSH_FULL;
    end else if (is_pop && (cnt_q == '0)) begin
      status_res = ST_POP_EMPTY;
    end else begin
      status_res = ST_OK;
    end

    occ_wide = {{OCC_W{1'b0}}, cnt_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      min_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      min_cnt_q <= min_cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {status_res, (cnt_d == '0), occ_wide[OCC_W-1:0],
                     min_res, top_res, popped_res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_PAD - OUT_W){1'b0}}, out_data_q};

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("element count exceeds stack depth");

  a_min_le_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_cnt_q <= cnt_q)
    else $error("minimum count exceeds element count");

  a_min_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_cnt_q != '0))
    else $error("minimum row empty while elements are held");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("push did not grow the element count");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[3*DATA_W+OCC_W] == (out_data_q[3*DATA_W +: OCC_W] == '0)
                     || STACK_DEPTH >= 128))
    else $error("empty flag disagrees with occupancy");

endmodule

@@ src/mts_cell.sv @@
// ----------------------------------------------------------------------------
// mts_cell: one stack entry
// Holds one value and takes the value of its upper or lower neighbor on a shift.
// ----------------------------------------------------------------------------
module mts_cell (
  input  logic                       clk_i,
  input  mts_pkg::shift_ctrl_t       ctrl_i,
  input  logic [mts_pkg::DATA_W-1:0] up_i,
  input  logic [mts_pkg::DATA_W-1:0] down_i,
  output logic [mts_pkg::DATA_W-1:0] data_o
);
  import mts_pkg::*;

  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      data_q <= up_i;
    end else if (ctrl_i.pop) begin
      data_q <= down_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ src/mts_chain.sv @@
// ----------------------------------------------------------------------------
// mts_chain: row of stack cells
// Cell 0 is the top of the stack; all cells shift together on a push or pop.
// ----------------------------------------------------------------------------
module mts_chain #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  mts_pkg::shift_ctrl_t       ctrl_i,
  input  logic [mts_pkg::DATA_W-1:0] push_data_i,
  output logic [mts_pkg::DATA_W-1:0] top_o,
  output logic [mts_pkg::DATA_W-1:0] next_o
);
  import mts_pkg::*;

  logic [DATA_W-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_val;
    logic [DATA_W-1:0] down_val;

    if (i == 0) begin : g_first
      assign up_val = push_data_i;
    end else begin : g_inner
      assign up_val = cell_data[i-1];
    end

    // The bottom cell only empties on a pop; what it takes then is never read.
    if (i == DEPTH - 1) begin : g_last
      assign down_val = '0;
    end else begin : g_upper
      assign down_val = cell_data[i+1];
    end

    mts_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .up_i   (up_val),
      .down_i (down_val),
      .data_o (cell_data[i])
    );
  end

  assign top_o  = cell_data[0];
  assign next_o = cell_data[1];

endmodule

@@ tb/min_tracking_stack_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb: self-checking bench for the minimum tracking stack
// A queue of stack operations feeds a stream driver. A local model of both
// stacks predicts every result item, and a monitor compares each result item
// field by field; both sides of the stream idle at random in the first two phases.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;
  import mts_pkg::*;

  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0] opcode;
    logic [31:0]     value;
  } stack_op_t;

  typedef struct packed {
    logic [31:0]   popped;
    logic [31:0]   top;
    logic [31:0]   minimum;
    logic [6:0]    occupancy;
    logic          is_empty;
    status_e       status;
  } stack_view_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  stack_op_t   pending_ops[$];
  stack_view_t expected_views[$];

  // Local copy of the element and minimum stacks.
  logic [31:0] elem_stack[STACK_DEPTH];
  logic [31:0] min_stack[STACK_DEPTH];
  int unsigned elem_cnt = 0;
  int unsigned min_cnt  = 0;

  int unsigned sent_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned error_cnt     = 0;
  int unsigned result_cnt    = 0;
  int unsigned push_cnt      = 0;
  int unsigned pop_cnt       = 0;
  int unsigned full_drop_cnt = 0;
  int unsigned empty_pop_cnt = 0;
  int unsigned observe_cnt   = 0;
  int unsigned peak_occ      = 0;

  min_tracking_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Idle percentages per phase: receiver-heavy gaps, then sender-heavy, then none.
  function automatic int unsigned sender_idle_pct(int unsigned sent);
    if (sent < 600) return 22;
    if (sent < 1200) return 47;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct(int unsigned sent);
    if (sent < 600) return 47;
    if (sent < 1200) return 22;
    return 0;
  endfunction

  // Mix of full-range values, a narrow band that produces many equal minimums,
  // and the signed extremes together with zero and minus one.
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom();
    if (sel < 8) return 32'($signed($urandom_range(0, 6)) - 3);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_passive_op();
    return ($urandom_range(0, 1) != 0) ? OP_OBSERVE : OP_UNUSED;
  endfunction

  task automatic queue_op(logic [OP_W-1:0] opcode, logic [31:0] value);
    stack_op_t op;
    op.opcode = opcode;
    op.value  = value;
    pending_ops.push_back(op);
  endtask

  // Applies one operation to the local stacks and returns the expected view.
  function automatic stack_view_t apply_stack_op(stack_op_t op);
    stack_view_t view;
    logic        to_min;
    view        = '0;
    view.status = ST_OK;
    case (op.opcode)
      OP_PUSH: begin
        if (elem_cnt >= STACK_DEPTH) begin
          view.status = ST_PUSH_FULL;
        end else begin
          to_min = (min_cnt == 0) ||
                   ($signed(op.value) <= $signed(min_stack[min_cnt-1]));
          elem_stack[elem_cnt] = op.value;
          elem_cnt++;
          if (to_min && min_cnt < STACK_DEPTH) begin
            min_stack[min_cnt] = op.value;
            min_cnt++;
          end
        end
      end
      OP_POP: begin
        if (elem_cnt == 0) begin
          view.status = ST_POP_EMPTY;
        end else begin
          elem_cnt--;
          view.popped = elem_stack[elem_cnt];
          if (min_cnt > 0 && min_stack[min_cnt-1] == view.popped) min_cnt--;
        end
      end
      default: ;
    endcase
    if (elem_cnt > 0) begin
      view.top = elem_stack[elem_cnt-1];
      if (min_cnt > 0) view.minimum = min_stack[min_cnt-1];
    end
    view.occupancy = 7'(elem_cnt);
    view.is_empty  = (elem_cnt == 0);
    return view;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val,
                                      logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
      error_cnt++;
    end
  endfunction

  // Stimulus: a short directed sequence, then random runs of fills, drains and
  // mixed traffic so the stack keeps hitting both full and empty.
  initial begin
    int unsigned total;
    int unsigned seg_len;
    int unsigned push_pct;
    int unsigned kind;

    queue_op(OP_OBSERVE, 32'h1234_5678);
    queue_op(OP_POP,     32'hffff_ffff);
    queue_op(OP_UNUSED,  32'h0000_0000);
    queue_op(OP_PUSH,    32'h7fff_ffff);
    queue_op(OP_PUSH,    32'h0000_0005);
    queue_op(OP_PUSH,    32'h0000_0005);
    queue_op(OP_PUSH,    32'h8000_0000);
    queue_op(OP_PUSH,    32'h8000_0000);
    queue_op(OP_PUSH,    32'hffff_ffff);
    queue_op(OP_OBSERVE, 32'hffff_ffff);
    queue_op(OP_UNUSED,  32'h5555_5555);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_PUSH,    32'haaaa_aaaa);
    queue_op(OP_PUSH,    32'h5555_5555);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_POP,     32'h0000_0000);
    queue_op(OP_POP,     32'h0000_0000);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        // Fill past the depth so that pushes on a full stack get dropped.
        seg_len = $urandom_range(66, 74);
        for (int i = 0; i < seg_len; i++) begin
          if ($urandom_range(0, 19) == 0) queue_op(pick_passive_op(), $urandom());
          else queue_op(OP_PUSH, pick_value());
        end
      end else if (kind < 6) begin
        seg_len = $urandom_range(66, 74);
        for (int i = 0; i < seg_len; i++) begin
          if ($urandom_range(0, 19) == 0) queue_op(pick_passive_op(), $urandom());
          else queue_op(OP_POP, $urandom());
        end
      end else begin
        seg_len  = $urandom_range(20, 60);
        push_pct = $urandom_range(30, 70);
        for (int i = 0; i < seg_len; i++) begin
          if ($urandom_range(0, 9) == 0) queue_op(pick_passive_op(), $urandom());
          else if ($urandom_range(0, 99) < push_pct) queue_op(OP_PUSH, pick_value());
          else queue_op(OP_POP, $urandom());
        end
      end
      total += seg_len;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: presents the next queued item and holds it until accepted.
  always @(posedge clk_i) begin
    stack_op_t op;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct(sent_cnt)) begin
        op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= op.value;
        s_axis_tuser  <= op.opcode;
        sent_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct(sent_cnt));
    end
  end

  // Scoreboard: predicts on each accepted input item and checks each result item.
  always @(posedge clk_i) begin
    stack_op_t   op;
    stack_view_t view;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      op.opcode = s_axis_tuser;
      op.value  = s_axis_tdata;
      view = apply_stack_op(op);
      expected_views.push_back(view);
      case (view.status)
        ST_PUSH_FULL: full_drop_cnt++;
        ST_POP_EMPTY: empty_pop_cnt++;
        default: begin
          if (op.opcode == OP_PUSH) push_cnt++;
          else if (op.opcode == OP_POP) pop_cnt++;
          else observe_cnt++;
        end
      endcase
      if (elem_cnt > peak_occ) peak_occ = elem_cnt;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (expected_views.size() == 0) begin
        $error("result item with no pending expectation: %h", m_axis_tdata);
        error_cnt++;
      end else begin
        view = expected_views.pop_front();
        check_field("popped_value", view.popped,            m_axis_tdata[31:0]);
        check_field("top_value",    view.top,               m_axis_tdata[63:32]);
        check_field("minimum",      view.minimum,           m_axis_tdata[95:64]);
        check_field("occupancy",    32'(view.occupancy),    32'(m_axis_tdata[102:96]));
        check_field("is_empty",     32'(view.is_empty),     32'(m_axis_tdata[103]));
        check_field("status",       32'(view.status),       32'(m_axis_tdata[105:104]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_views.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_views.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_views.size() != 0) begin
      $error("%0d expected results never arrived", expected_views.size());
      error_cnt++;
    end
    $display("Checked %0d results: %0d pushes, %0d pops, %0d observes",
             result_cnt, push_cnt, pop_cnt, observe_cnt);
    $display("Dropped pushes on full: %0d, pops on empty: %0d, peak depth %0d, errors %0d",
             full_drop_cnt, empty_pop_cnt, peak_occ, error_cnt);
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
